### sv/wspm_pkg.sv
`default_nettype none

package wspm_pkg;

  // Pattern capacity used as the default of the top level parameter
  localparam int unsigned MaxTokensDefault = 16;

  // Token byte that matches any text byte
  localparam logic [7:0] WildcardByte = 8'd46;

  // Kind of request carried on the input tuser
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_e;

  // Shared control broadcast from the top level to every cell
  typedef struct packed {
    logic       init;  // reload the reachable bit with its start value
    logic       step;  // consume one text byte
    logic [7:0] sym;   // the text byte
  } cell_ctl_t;

  // Signals that ripple from one cell to the next
  typedef struct packed {
    logic carry;  // reachable position skips a repeat token into the next one
    logic adv;    // single token matched, advance to the next position
  } chain_t;

endpackage

`default_nettype wire

### sv/wildcard_star_pattern_matcher.sv
`default_nettype none

// Channel   Dir  Fields (low bit up)                        Handshake
// s_axis    in   tuser: action[1:0]                          s_axis_tvalid_i / s_axis_tready_o
//                tdata: symbol[7:0], repeat_req[8], pad
// m_axis    out  tdata: matched[0], overflow[1], pad         m_axis_tvalid_o / m_axis_tready_i
//
// A new request can be accepted on every clock edge unless input is held off (see below).
// The text step is one ripple through the row of cells (skip of repeat tokens
// and hand-on of single matches), so MAX_TOKENS sets the depth of that path.
// The result of an end-of-text request sits in the output register; input is
// held off only while that register is full and the sink stalls.
// Reset empties the pattern, clears overflow and leaves only position zero
// reachable; the token store itself is not cleared.

module wildcard_star_pattern_matcher
  import wspm_pkg::*;
#(
  parameter int unsigned MAX_TOKENS = MaxTokensDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // symbol[7:0], repeat_req[8], zero pad [15:9]
  input  wire  [1:0]  s_axis_tuser_i,   // action[1:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // matched[0], overflow[1], zero pad [7:2]
);

  localparam int unsigned CntW = $clog2(MAX_TOKENS + 1);

  // Unpack the request
  action_e    action;
  logic [7:0] symbol;
  logic       repeat_req;
  logic       in_fire;

  assign action     = action_e'(s_axis_tuser_i);
  assign symbol     = s_axis_tdata_i[7:0];
  assign repeat_req = s_axis_tdata_i[8];
  assign in_fire    = s_axis_tvalid_i & s_axis_tready_o;

  // Pattern length and sticky overflow
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            final_q, final_d;   // reachable bit of the position after the last cell

  // Cell row
  cell_ctl_t              ctl;
  chain_t  [MAX_TOKENS:0] chain;
  logic    [MAX_TOKENS:0] closed;
  logic    [MAX_TOKENS-1:0] active;
  logic    [MAX_TOKENS-1:0] wr;
  logic                   do_append;

  assign do_append = in_fire & (action == ACT_APPEND);

  assign ctl.init = in_fire & ((action == ACT_CLEAR) || (action == ACT_APPEND)
                               || (action == ACT_END));
  assign ctl.step = in_fire & (action == ACT_TEXT);
  assign ctl.sym  = symbol;

  // Nothing ripples into the first cell
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    assign active[i] = count_q > CntW'(i);
    assign wr[i]     = do_append & (count_q == CntW'(i));

    wspm_cell #(
      .ReachInit (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .wr_i      (wr[i]),
      .wr_byte_i (symbol),
      .wr_rep_i  (repeat_req),
      .active_i  (active[i]),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1]),
      .closed_o  (closed[i])
    );
  end

  // The position past the last cell holds no token; it only collects
  assign closed[MAX_TOKENS] = final_q | chain[MAX_TOKENS].carry;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    final_d = final_q;
    if (in_fire) begin
      unique case (action)
        ACT_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
          final_d = 1'b0;
        end
        ACT_APPEND: begin
          // drop the token once full and flag it until the next clear
          if (count_q < CntW'(MAX_TOKENS)) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          final_d = 1'b0;
        end
        ACT_TEXT: begin
          final_d = chain[MAX_TOKENS].adv;
        end
        ACT_END: begin
          final_d = 1'b0;
        end
        default: begin
          final_d = final_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      final_q <= final_d;
    end
  end

  // Output register: accept while it is empty or being drained
  logic out_valid_q, out_valid_d;
  logic matched_q, overflow_q;
  logic emit;

  assign emit            = in_fire & (action == ACT_END);
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Whole-string match: the position just past the pattern is reachable
  always_ff @(posedge clk_i) begin
    if (emit) begin
      matched_q  <= closed[count_q];
      overflow_q <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, overflow_q, matched_q};

endmodule

`default_nettype wire

### sv/wspm_cell.sv
`default_nettype none

module wspm_cell
  import wspm_pkg::*;
#(
  parameter bit ReachInit = 1'b0
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctl_t  ctl_i,
  input  wire        wr_i,
  input  wire  [7:0] wr_byte_i,
  input  wire        wr_rep_i,
  input  wire        active_i,
  input  chain_t     chain_i,
  output chain_t     chain_o,
  output logic       closed_o
);

  logic [7:0] byte_q;
  logic       rep_q;
  logic       reach_q, reach_d;
  logic       hit;

  // Token store: written once per append, no reset needed
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      byte_q <= wr_byte_i;
      rep_q  <= wr_rep_i;
    end
  end

  assign closed_o = reach_q | chain_i.carry;
  assign hit      = active_i & closed_o & ((byte_q == WildcardByte) | (byte_q == ctl_i.sym));

  assign chain_o.carry = active_i & closed_o & rep_q;
  assign chain_o.adv   = hit & ~rep_q;

  always_comb begin
    reach_d = reach_q;
    if (ctl_i.init) begin
      reach_d = ReachInit;
    end else if (ctl_i.step) begin
      // a repeat token stays put, a single token hands on to the next cell
      reach_d = (hit & rep_q) | chain_i.adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= ReachInit;
    end else begin
      reach_q <= reach_d;
    end
  end

endmodule

`default_nettype wire

### dv/tb_wildcard_star_pattern_matcher.sv
`default_nettype none

// Self-checking bench for the whole-string pattern matcher.
// A request queue filled up front feeds a clocked driver; every accepted request
// is applied at once to a local model of the token store and the reachable set.
// End-of-text requests push an expected verdict. A clocked monitor pops and
// compares each verdict the block returns.

module tb_wildcard_star_pattern_matcher;
  import wspm_pkg::*;

  localparam int Cap = MaxTokensDefault;

  typedef struct {
    action_e    act;
    logic [7:0] sym;
    logic       rep;
    logic       drain;  // not a request: hold the sender until all verdicts are in
  } match_req_t;

  typedef struct {
    logic matched;
    logic overflow;
  } verdict_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [15:0] s_tdata  = '0;  // symbol[7:0], repeat_req[8], zero pad [15:9]
  logic [1:0]  s_tuser  = ACT_CLEAR;  // action[1:0]
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [7:0]  m_tdata;  // matched[0], overflow[1], zero pad [7:2]

  match_req_t  pending_req_q[$];
  verdict_t    expected_verdict_q[$];
  logic [7:0]  plan_byte[$];
  logic        plan_rep[$];

  // Local copy of the pattern store and matcher state
  logic [7:0]  pat_byte[Cap];
  logic        pat_rep[Cap];
  int unsigned pat_len = 0;
  logic [Cap:0] live    = {{Cap{1'b0}}, 1'b1};
  logic        ovf      = 1'b0;

  logic        calm     = 1'b0;
  int          errors   = 0;
  int          n_sent   = 0;
  int          n_checked = 0;
  int          n_matched = 0;
  int          n_ovf    = 0;

  always #10 clk_i = ~clk_i;

  wildcard_star_pattern_matcher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata)
  );

  // Add every position reached by skipping a repeat token; the chain runs forward
  // so one pass covers a run of repeat tokens.
  function automatic logic [Cap:0] skip_repeats(logic [Cap:0] s);
    for (int i = 0; i < Cap; i++)
      if (i < pat_len && s[i] && pat_rep[i]) s[i+1] = 1'b1;
    return s;
  endfunction

  // Advance the local matcher by one accepted request
  function automatic void apply_request(match_req_t r);
    logic [Cap:0] cur;
    logic [Cap:0] nxt;
    case (r.act)
      ACT_CLEAR: begin
        pat_len = 0;
        ovf     = 1'b0;
        live    = {{Cap{1'b0}}, 1'b1};
      end
      ACT_APPEND: begin
        if (pat_len < Cap) begin
          pat_byte[pat_len] = r.sym;
          pat_rep[pat_len]  = r.rep;
          pat_len++;
        end else begin
          ovf = 1'b1;  // drop the token, keep the flag until the next clear
        end
        live = {{Cap{1'b0}}, 1'b1};
      end
      ACT_TEXT: begin
        cur = skip_repeats(live);
        nxt = '0;
        for (int i = 0; i < Cap; i++)
          if (i < pat_len && cur[i] && (pat_byte[i] == WildcardByte || pat_byte[i] == r.sym))
            if (pat_rep[i]) nxt[i] = 1'b1;
            else            nxt[i+1] = 1'b1;
        live = nxt;
      end
      default: begin
        cur = skip_repeats(live);
        expected_verdict_q.push_back('{matched: cur[pat_len], overflow: ovf});
        live = {{Cap{1'b0}}, 1'b1};
      end
    endcase
  endfunction

  task automatic push_req(action_e a, logic [7:0] s, logic rep);
    pending_req_q.push_back('{act: a, sym: s, rep: rep, drain: 1'b0});
  endtask

  task automatic push_drain();
    pending_req_q.push_back('{act: ACT_CLEAR, sym: 8'h00, rep: 1'b0, drain: 1'b1});
  endtask

  // Bias token bytes towards a few letters so that texts built from them match
  function automatic logic [7:0] pick_token_byte();
    case ($urandom_range(0, 6))
      0:       return WildcardByte;
      1:       return 8'h00;
      2:       return 8'hFF;
      3:       return 8'h2A;  // a literal star
      4:       return 8'($urandom);
      default: return 8'($urandom_range(8'h61, 8'h63));
    endcase
  endfunction

  // Clear, then append k tokens; anything past the capacity overflows
  task automatic load_pattern(int k);
    logic [7:0] b;
    logic       rp;
    plan_byte.delete();
    plan_rep.delete();
    push_req(ACT_CLEAR, 8'($urandom), 1'($urandom));
    repeat (k) begin
      b  = pick_token_byte();
      rp = 1'($urandom);
      plan_byte.push_back(b);
      plan_rep.push_back(rp);
      push_req(ACT_APPEND, b, rp);
    end
  endtask

  // Build a text that the planned pattern accepts, sometimes spoil it, then end it
  task automatic queue_text();
    logic [7:0] txt[$];
    int         n;
    int         reps;
    n = (plan_byte.size() < Cap) ? plan_byte.size() : Cap;
    for (int i = 0; i < n; i++) begin
      reps = plan_rep[i] ? $urandom_range(0, 3) : 1;
      repeat (reps) txt.push_back(plan_byte[i] == WildcardByte ? 8'($urandom) : plan_byte[i]);
    end
    case ($urandom_range(0, 5))
      0: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
      1: txt.push_back(8'($urandom));
      2: if (txt.size() > 0) void'(txt.pop_back());
      default: ;
    endcase
    foreach (txt[i]) push_req(ACT_TEXT, txt[i], 1'($urandom));
    push_req(ACT_END, 8'($urandom), 1'($urandom));
  endtask

  // Driver: offer the head of the queue, hold it until taken, idle in bursts.
  // The model is advanced here so that a drain marker sees every verdict due.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    match_req_t r;
    int         src_gap;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_valid && s_ready) begin
        r.act = action_e'(s_tuser);
        r.sym = s_tdata[7:0];
        r.rep = s_tdata[8];
        apply_request(r);
        n_sent++;
      end
      calm <= (pending_req_q.size() < 80);
      if (!(s_valid && !s_ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_valid <= 1'b0;
        end else if (pending_req_q.size() == 0) begin
          s_valid <= 1'b0;
        end else if (pending_req_q[0].drain) begin
          s_valid <= 1'b0;
          if (expected_verdict_q.size() == 0) void'(pending_req_q.pop_front());
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 11);
          s_valid <= 1'b0;
        end else begin
          r = pending_req_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {7'd0, r.rep, r.sym};
          s_tuser <= r.act;
        end
      end
    end
  end

  // Monitor: check each verdict taken, and stall the sink in bursts plus two
  // long hold-offs so that the output register fills and input backs up.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_t want;
    int       sink_gap;
    int       hold_left;
    int       holds_done;
    if (!rst_ni) begin
      m_ready <= 1'b0;
      sink_gap   = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_verdict_q.size() == 0) begin
          $error("verdict with none expected: tdata %h", m_tdata);
          errors++;
        end else begin
          want = expected_verdict_q.pop_front();
          if (m_tdata[0] !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, m_tdata[0]);
            errors++;
          end
          if (m_tdata[1] !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, m_tdata[1]);
            errors++;
          end
          n_checked++;
          n_matched += want.matched;
          n_ovf     += want.overflow;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if ((holds_done == 0 && n_checked >= 8) ||
                   (holds_done == 1 && n_checked >= 45)) begin
        holds_done++;
        hold_left = 60;
        m_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 11);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int  k;
    bit  mid_drain;
    mid_drain = 1'b0;

    // Empty pattern: only the empty text matches
    push_req(ACT_END, 8'hFF, 1'b1);
    push_req(ACT_TEXT, 8'h00, 1'b0);
    push_req(ACT_END, 8'h00, 1'b0);
    // Dot-star takes the empty text and any bytes
    push_req(ACT_CLEAR, 8'h5A, 1'b1);
    push_req(ACT_APPEND, WildcardByte, 1'b1);
    push_req(ACT_END, 8'h00, 1'b0);
    push_req(ACT_TEXT, 8'hFF, 1'b1);
    push_req(ACT_TEXT, 8'h00, 1'b0);
    push_req(ACT_END, 8'h00, 1'b0);
    // Literal star, byte extremes, and a repeat token skipped entirely
    push_req(ACT_CLEAR, 8'h00, 1'b0);
    push_req(ACT_APPEND, 8'h61, 1'b0);
    push_req(ACT_APPEND, 8'h2A, 1'b0);
    push_req(ACT_APPEND, 8'hFF, 1'b1);
    push_req(ACT_APPEND, 8'h00, 1'b0);
    push_req(ACT_TEXT, 8'h61, 1'b0);
    push_req(ACT_TEXT, 8'h2A, 1'b0);
    push_req(ACT_TEXT, 8'h00, 1'b0);
    push_req(ACT_END, 8'h00, 1'b0);
    // A text dot is no match for a literal star
    push_req(ACT_TEXT, 8'h61, 1'b0);
    push_req(ACT_TEXT, WildcardByte, 1'b0);
    push_req(ACT_END, 8'h00, 1'b0);
    push_drain();

    // Random part: mostly load-then-match sequences, some loose requests
    while (pending_req_q.size() < 520) begin
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 4))
          push_req(action_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end else begin
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
        load_pattern(k);
        repeat ($urandom_range(1, 4)) queue_text();
      end
      if (!mid_drain && pending_req_q.size() > 250) begin
        push_drain();
        mid_drain = 1'b1;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_req_q.size() != 0 || s_valid) @(posedge clk_i);
    while (expected_verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests and %0d verdicts", n_sent, n_checked);
    $display("of which %0d matched and %0d carried overflow", n_matched, n_ovf);
    if (errors == 0 && expected_verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
